>>> sv/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg
// Shared constants, command codes and register indexes of the double
// columnar transposition block.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int KEY_MAX_DEF = 16;
  localparam int ROW_MAX_DEF = 64;

  localparam int KEY_CHARS  = 16;  // key characters held in the two key registers
  localparam int BYTE_W     = 8;
  localparam int CMD_W      = 2;
  localparam int KEY_LEN_W  = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_FETCH   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_KEY_LO   = 2'd0,
    REG_KEY_HI   = 2'd1,
    REG_KEY_LEN  = 2'd2,
    REG_DEC_MODE = 2'd3
  } reg_idx_t;

endpackage

>>> sv/double_columnar_transposition.sv
// ----------------------------------------------------------------------------
// double_columnar_transposition
// Double columnar transposition: loads message bytes into a store, then
// returns the transposed text one byte per fetch request.
// ----------------------------------------------------------------------------
//  channel   ports                                     handshake
//  input     in_cmd, in_data_byte                      start && !busy
//  result    out_byte, out_is_last                     out_valid, one cycle
//  config    psel penable pwrite paddr pwdata prdata   apb write, pready = 1
//
//  load and restart requests finish in the accept cycle; busy stays low
//  a fetch runs a key ranking walk over the L key characters (L = key length)
//  plus two passes of the shared divider
//  a fetch past the last byte gives no result and ends after one divider pass;
//  a fetch with nothing loaded ends in the accept cycle
//  the result strobe is high in the first cycle with busy low; no stall
//  reset clears the state, counters, result strobe and config registers only; the store needs no clearing pass
// ----------------------------------------------------------------------------
module double_columnar_transposition
  import dct_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF,
  parameter int ROW_MAX = ROW_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [BYTE_W-1:0]     in_data_byte,
  output logic                  out_valid,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_is_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int STORE_DEPTH = KEY_MAX * ROW_MAX;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + KEY_MAX);
  localparam int KIDX_W      = $clog2(KEY_MAX);
  localparam int LEN_W       = $clog2(KEY_MAX + 1);
  localparam int PROD_W      = CNT_W + LEN_W;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_RANK      = 12'b0000_0000_0010,
    ST_ROWS_GO   = 12'b0000_0000_0100,
    ST_ROWS_WAIT = 12'b0000_0000_1000,
    ST_TOTAL     = 12'b0000_0001_0000,
    ST_CHECK     = 12'b0000_0010_0000,
    ST_POS_WAIT  = 12'b0000_0100_0000,
    ST_LOOK1     = 12'b0000_1000_0000,
    ST_LOOK2     = 12'b0001_0000_0000,
    ST_INDEX     = 12'b0010_0000_0000,
    ST_READ      = 12'b0100_0000_0000,
    ST_DATA      = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] key_lo_r;
  logic [CFG_DATA_W-1:0] key_hi_r;
  logic [KEY_LEN_W-1:0]  key_len_r;
  logic                  dec_mode_r;

  logic [CNT_W-1:0]  loaded_r;
  logic [CNT_W-1:0]  emitted_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  rank_i_r;
  logic [KIDX_W-1:0] perm_r [KEY_MAX];
  logic [KIDX_W-1:0] p1_r;
  logic [KIDX_W-1:0] p2_r;
  logic [CNT_W-1:0]  rows_r;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  idx_r;

  logic [KEY_CHARS-1:0][BYTE_W-1:0] key_all;
  logic [LEN_W-1:0]  len_eff;
  logic              accept;
  logic              is_fetch;
  logic              load_ok;
  logic              cfg_wr;
  reg_idx_t          reg_idx;

  logic [KIDX_W-1:0] rank_val;
  logic [KIDX_W-1:0] perm_waddr;
  logic [KIDX_W-1:0] perm_wdata;
  logic [KIDX_W-1:0] perm_raddr;
  logic [KIDX_W-1:0] perm_rdata;

  logic              div_start;
  logic              div_done;
  logic [CNT_W-1:0]  div_dvd;
  logic [CNT_W-1:0]  div_dsr;
  logic [CNT_W-1:0]  div_quo;
  logic [CNT_W-1:0]  div_rem;

  logic [PROD_W-1:0] total_calc;
  logic [PROD_W-1:0] idx_calc;
  logic [BYTE_W-1:0] ram_rdata;

  // ---------------- request decode ----------------

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign is_fetch = accept && (cmd_t'(in_cmd) == CMD_FETCH);
  assign load_ok  = accept && (cmd_t'(in_cmd) == CMD_LOAD) &&
                    !(!dec_mode_r && (in_data_byte == SPACE_CHAR)) &&
                    (loaded_r < CNT_W'(STORE_DEPTH));

  assign key_all = {key_hi_r, key_lo_r};

  always_comb begin
    if (key_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_len_r > KEY_LEN_W'(KEY_MAX)) begin
      len_eff = LEN_W'(KEY_MAX);
    end else begin
      len_eff = LEN_W'(key_len_r);
    end
  end

  // ---------------- configuration port ----------------

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LO:   prdata = key_lo_r;
      REG_KEY_HI:   prdata = key_hi_r;
      REG_KEY_LEN:  prdata = CFG_DATA_W'(key_len_r);
      REG_DEC_MODE: prdata = CFG_DATA_W'(dec_mode_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------- key ranking ----------------

  dct_rank #(.KEY_MAX(KEY_MAX)) u_rank (
    .key  (key_all[KEY_MAX-1:0]),
    .len  (len_r),
    .idx  (rank_i_r[KIDX_W-1:0]),
    .rank (rank_val)
  );

  // encrypt keeps the inverse permutation, decrypt the rank itself
  assign perm_waddr = dec_mode_r ? rank_i_r[KIDX_W-1:0] : rank_val;
  assign perm_wdata = dec_mode_r ? rank_val : rank_i_r[KIDX_W-1:0];

  always_comb begin
    if (state_r == ST_LOOK1) begin
      perm_raddr = dec_mode_r ? div_rem[KIDX_W-1:0] : div_quo[KIDX_W-1:0];
    end else begin
      perm_raddr = p1_r;
    end
  end

  assign perm_rdata = perm_r[perm_raddr];

  // ---------------- shared divider ----------------

  always_comb begin
    div_start = (state_r == ST_ROWS_GO) ||
                ((state_r == ST_CHECK) && (emitted_r < total_r));
    if (state_r == ST_CHECK) begin
      div_dvd = emitted_r;
      div_dsr = dec_mode_r ? CNT_W'(len_r) : rows_r;
    end else begin
      // rows = ceil(n / L)
      div_dvd = loaded_r + CNT_W'(len_r) - CNT_W'(1);
      div_dsr = CNT_W'(len_r);
    end
  end

  dct_div #(.W(CNT_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign total_calc = PROD_W'(rows_r) * PROD_W'(len_r);

  always_comb begin
    if (dec_mode_r) begin
      idx_calc = PROD_W'(p2_r) * PROD_W'(rows_r) + PROD_W'(div_quo);
    end else begin
      idx_calc = PROD_W'(div_rem) * PROD_W'(len_r) + PROD_W'(p2_r);
    end
  end

  // ---------------- message store ----------------

  dct_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (load_ok),
    .waddr (loaded_r[ADDR_W-1:0]),
    .wdata (in_data_byte),
    .re    (state_r == ST_READ),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------- sequencer ----------------

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (is_fetch && (loaded_r != '0)) state_nxt = ST_RANK;
      ST_RANK:      if (rank_i_r == len_r - LEN_W'(1)) state_nxt = ST_ROWS_GO;
      ST_ROWS_GO:   state_nxt = ST_ROWS_WAIT;
      ST_ROWS_WAIT: if (div_done) state_nxt = ST_TOTAL;
      ST_TOTAL:     state_nxt = ST_CHECK;
      ST_CHECK:     state_nxt = (emitted_r < total_r) ? ST_POS_WAIT : ST_IDLE;
      ST_POS_WAIT:  if (div_done) state_nxt = ST_LOOK1;
      ST_LOOK1:     state_nxt = ST_LOOK2;
      ST_LOOK2:     state_nxt = ST_INDEX;
      ST_INDEX:     state_nxt = ST_READ;
      ST_READ:      state_nxt = ST_DATA;
      ST_DATA:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
      key_lo_r    <= '0;
      key_hi_r    <= '0;
      key_len_r   <= KEY_LEN_W'(1);
      dec_mode_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DATA);
      if (accept && (cmd_t'(in_cmd) == CMD_RESTART)) begin
        loaded_r  <= '0;
        emitted_r <= '0;
      end
      if (load_ok) begin
        loaded_r <= loaded_r + CNT_W'(1);
      end
      if (state_r == ST_DATA) begin
        emitted_r <= emitted_r + CNT_W'(1);
      end
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_KEY_LO:   key_lo_r   <= pwdata;
          REG_KEY_HI:   key_hi_r   <= pwdata;
          REG_KEY_LEN:  key_len_r  <= pwdata[KEY_LEN_W-1:0];
          REG_DEC_MODE: dec_mode_r <= pwdata[0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_fetch) begin
      len_r    <= len_eff;
      rank_i_r <= '0;
    end
    if (state_r == ST_RANK) begin
      perm_r[perm_waddr] <= perm_wdata;
      rank_i_r           <= rank_i_r + LEN_W'(1);
    end
    if ((state_r == ST_ROWS_WAIT) && div_done) begin
      rows_r <= div_quo;
    end
    if (state_r == ST_TOTAL) begin
      total_r <= total_calc[CNT_W-1:0];
    end
    if (state_r == ST_LOOK1) begin
      p1_r <= perm_rdata;
    end
    if (state_r == ST_LOOK2) begin
      p2_r <= perm_rdata;
    end
    if (state_r == ST_INDEX) begin
      idx_r <= idx_calc[CNT_W-1:0];
    end
    if (state_r == ST_DATA) begin
      // cells past the loaded bytes read as zero
      out_byte_r <= (idx_r < loaded_r) ? ram_rdata : '0;
      out_last_r <= ((emitted_r + CNT_W'(1)) == total_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_last = out_last_r;

endmodule

>>> sv/dct_ram.sv
// ----------------------------------------------------------------------------
// dct_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dct_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/dct_div.sv
// ----------------------------------------------------------------------------
// dct_div
// Shared restoring divider, one quotient bit per cycle. done pulses for one
// cycle when quotient and remainder are final; they hold until the next start.
// ----------------------------------------------------------------------------
module dct_div #(
  parameter  int W  = 11,
  localparam int CW = $clog2(W + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  logic          act_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dsr_r;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_nxt;
  logic [W-1:0]  quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    ge      = (shifted >= {1'b0, dsr_r});
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        cnt_r <= CW'(W);
      end else if (act_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (act_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> sv/dct_rank.sv
// ----------------------------------------------------------------------------
// dct_rank
// Compare bank: rank of one key character among the first len characters,
// ties broken by position.
// ----------------------------------------------------------------------------
module dct_rank
  import dct_pkg::*;
#(
  parameter  int KEY_MAX = KEY_MAX_DEF,
  localparam int KIDX_W  = $clog2(KEY_MAX),
  localparam int LEN_W   = $clog2(KEY_MAX + 1)
) (
  input  logic [KEY_MAX-1:0][BYTE_W-1:0] key,
  input  logic [LEN_W-1:0]               len,
  input  logic [KIDX_W-1:0]              idx,
  output logic [KIDX_W-1:0]              rank
);

  logic [BYTE_W-1:0]  ki;
  logic [KEY_MAX-1:0] below;

  always_comb begin
    ki = key[idx];
    for (int j = 0; j < KEY_MAX; j++) begin
      below[j] = (LEN_W'(j) < len) &&
                 ((key[j] < ki) || ((key[j] == ki) && (KIDX_W'(j) < idx)));
    end
    rank = KIDX_W'($countones(below));
  end

endmodule

>>> sv/dct_checker.sv
// ----------------------------------------------------------------------------
// dct_checker
// Port-level checks of the fetch sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module dct_checker
  import dct_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [CMD_W-1:0] in_cmd,
  input logic             out_valid
);

  // the block only goes busy for a fetch request
  a_busy_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_cmd == CMD_FETCH)))
    else $error("busy rose without a fetch request");

  // a result ends a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobe outside the end of a fetch");

  // at most one result per fetch, never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a result shows in the cycle in which busy falls or not at all
  a_strobe_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result strobe not aligned to end of fetch");

endmodule

bind double_columnar_transposition dct_checker u_dct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .out_valid (out_valid)
);
